@@ src/sha_pkg.sv @@
package sha_pkg;

   localparam int WordWidth = 32;
   localparam int NumRounds = 64;

   typedef logic [WordWidth-1:0] word_type;
   typedef word_type [7:0] hash_type;

   // Request from the top-level sequencer to the round engine.
   typedef struct packed {
      logic start;
   } core_ctrl_type;

   // Status from the round engine back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } core_stat_type;

   localparam hash_type InitHash = '{
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenStart = 6'd56;

   function automatic word_type round_k(input logic [5:0] t);
      word_type k;
      case (t)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

endpackage

@@ src/sha_if.sv @@
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last;
   modport source (output valid, data_byte, has_byte, last, input ready);
   modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        word_last;
   modport source (output valid, digest_word, word_last, input ready);
   modport sink (input valid, digest_word, word_last, output ready);
endinterface

interface sha_csr_if;
   logic valid;
   logic ready;
   logic double_mode;
   modport source (output valid, double_mode, input ready);
   modport sink (input valid, double_mode, output ready);
endinterface

@@ src/sha_round.sv @@
// One compression round per cycle over a 16-word rolling schedule window.
module sha_round import sha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  core_ctrl_type ctrl,
   input  logic [511:0]  block,
   input  hash_type      chain,
   output hash_type      vars,
   output core_stat_type stat
);

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

   word_type [15:0] w_ff, w_in;
   hash_type        v_ff, v_in;
   logic [5:0]      t_ff, t_in;
   logic            busy_ff, busy_in, done_ff, done_in;

   word_type a, b, c, d, e, f, g, h, s0, s1, w_new, wt, t1, t2, w2, w15;

   always_comb begin
      {h, g, f, e, d, c, b, a} = v_ff;
      w2  = w_ff[14];
      w15 = w_ff[1];
      s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
      s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
      w_new = s1 + w_ff[9] + s0 + w_ff[0];
      wt = w_ff[0];
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + round_k(t_ff) + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      w_in = w_ff;
      v_in = v_ff;
      t_in = t_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         for (int i = 0; i < 16; i++) w_in[i] = block[511-32*i -: 32];
         v_in = chain;
         t_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // w_ff[0] always holds W[t]; the window shifts down each round.
         w_in = {w_new, w_ff[15:1]};
         v_in = {g, f, e, d + t1, c, b, a, t1 + t2};
         t_in = t_ff + 6'd1;
         if (t_ff == 6'(NumRounds - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
      t_ff <= t_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign vars = v_ff;
   assign stat = '{busy: busy_ff, done: done_ff};

endmodule

@@ src/sha256_byte_stream_hasher_unit.sv @@
// SHA-256 byte stream hasher.
// Requests arrive on req one byte at a time: data_byte with has_byte set, and
// last set on the final byte. A request with has_byte low and last high ends
// the message without adding a byte (the empty message if none came before).
// A request with both low is accepted and ignored.
// The 64th byte of a block starts the round engine, which runs one round
// per cycle; req_ready stays low until that block has been added to the
// hash. A last request adds padding (1 to 64 bytes written one per cycle,
// one or two more blocks through the engine) and, in double mode, a second
// hash over the 32-byte digest.
// The digest leaves on rsp as eight 32-bit words, word 0 first, word_last
// on the eighth. req_ready stays low until all eight words are taken; a
// stalled receiver simply holds the block in its output state.
// csr sets double_mode and is always ready; write it only while idle.
// Reset (synchronous, active high) restores the initial hash, clears the
// length count, double_mode and the byte index; blk_ff is not reset.
module sha256_byte_stream_hasher_unit import sha_pkg::*; (
   input logic     clock,
   input logic     reset,
   sha_req_if.sink req,
   sha_rsp_if.source rsp,
   sha_csr_if.sink csr
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StPad   = 3'd1;
   localparam logic [2:0] StLen   = 3'd2;
   localparam logic [2:0] StRound = 3'd3;
   localparam logic [2:0] StAdd   = 3'd4;
   localparam logic [2:0] StOut   = 3'd5;
   localparam logic [2:0] StSecond = 3'd6;

   logic [2:0]   state_ff, state_in;
   logic [511:0] blk_ff, blk_in;
   hash_type     chain_ff, chain_in;
   logic [63:0]  len_ff, len_in;
   logic [5:0]   idx_ff, idx_in;
   logic         finishing_ff, finishing_in;   // padding block in flight is final
   logic         second_ff, second_in;
   logic         dbl_ff;
   logic [2:0]   oidx_ff, oidx_in;
   logic [2:0]   after_ff, after_in;            // where to go after a block

   core_ctrl_type ctrl;
   core_stat_type stat;
   hash_type      vars;

   // The engine loads the block as it is being completed, so the byte or
   // length written in the start cycle is part of it.
   sha_round u_round (
      .clock(clock), .reset(reset), .ctrl(ctrl), .block(blk_in),
      .chain(chain_ff), .vars(vars), .stat(stat));

   assign req.ready = (state_ff == StIdle);
   assign csr.ready = 1'b1;
   assign rsp.valid = (state_ff == StOut);
   assign rsp.digest_word = chain_ff[oidx_ff];
   assign rsp.word_last = (oidx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) dbl_ff <= 1'b0;
      else if (csr.valid) dbl_ff <= csr.double_mode;
   end

   always_comb begin
      state_in = state_ff;
      blk_in = blk_ff;
      chain_in = chain_ff;
      len_in = len_ff;
      idx_in = idx_ff;
      finishing_in = finishing_ff;
      second_in = second_ff;
      oidx_in = oidx_ff;
      after_in = after_ff;
      ctrl.start = 1'b0;
      unique case (state_ff)
         StIdle: begin
            if (req.valid) begin
               if (req.has_byte) begin
                  blk_in[511-8*idx_ff -: 8] = req.data_byte;
                  len_in = len_ff + 64'd8;
                  idx_in = idx_ff + 6'd1;
               end
               if (req.has_byte && idx_ff == 6'd63) begin
                  ctrl.start = 1'b1;
                  state_in = StRound;
                  after_in = req.last ? StPad : StIdle;
                  finishing_in = 1'b0;
               end else if (req.last) begin
                  state_in = StPad;
               end
            end
         end
         StPad: begin
            // Write 0x80 at the current slot, then zeros.
            blk_in[511-8*idx_ff -: 8] = (after_ff == StPad) ? PadByte : 8'h00;
            after_in = StLen;
            idx_in = idx_ff + 6'd1;
            if (after_ff == StPad && idx_ff < LenStart || after_ff != StPad && idx_ff < LenStart)
               begin
               if (idx_ff + 6'd1 == LenStart || idx_ff == 6'd63) state_in = StLen;
            end else if (idx_ff == 6'd63) begin
               ctrl.start = 1'b1;
               state_in = StRound;
               finishing_in = 1'b0;
            end
            if (idx_ff == 6'd55) state_in = StLen;
         end
         StLen: begin
            blk_in[63:0] = len_ff;
            ctrl.start = 1'b1;
            state_in = StRound;
            finishing_in = 1'b1;
         end
         StRound: begin
            if (stat.done) state_in = StAdd;
         end
         StAdd: begin
            for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] + vars[i];
            idx_in = '0;
            if (!finishing_ff) begin
               state_in = (after_ff == StIdle) ? StIdle : StPad;
               after_in = (after_ff == StIdle) ? StIdle : StLen;
               if (after_ff == StPad) after_in = StPad;
            end else if (dbl_ff && !second_ff) begin
               state_in = StSecond;
            end else begin
               state_in = StOut;
               oidx_in = '0;
            end
         end
         StSecond: begin
            for (int i = 0; i < 8; i++) blk_in[511-32*i -: 32] = chain_ff[i];
            chain_in = InitHash;
            len_in = 64'd256;
            idx_in = 6'd32;
            second_in = 1'b1;
            after_in = StPad;
            state_in = StPad;
         end
         StOut: begin
            if (rsp.ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  state_in = StIdle;
                  chain_in = InitHash;
                  len_in = '0;
                  idx_in = '0;
                  second_in = 1'b0;
                  after_in = StIdle;
               end
            end
         end
         default: state_in = StIdle;
      endcase
      // First pad cycle after a message end writes 0x80 only once.
      if (state_ff == StIdle && state_in == StPad) after_in = StPad;
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      oidx_ff <= oidx_in;
      if (reset) begin
         state_ff <= StIdle;
         chain_ff <= InitHash;
         len_ff <= '0;
         idx_ff <= '0;
         finishing_ff <= 1'b0;
         second_ff <= 1'b0;
         after_ff <= StIdle;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         len_ff <= len_in;
         idx_ff <= idx_in;
         finishing_ff <= finishing_in;
         second_ff <= second_in;
         after_ff <= after_in;
      end
   end

endmodule
